// ----- rtl/core/catmull_rom_path_smoother_unit_macros.svh -----
// Assertion macros shared by the path smoother modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef CATMULL_ROM_PATH_SMOOTHER_UNIT_MACROS_SVH
`define CATMULL_ROM_PATH_SMOOTHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crps assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crps assertion failed");

`endif

// ----- rtl/core/crps_pkg.sv -----
// Shared types and constants of the Catmull-Rom path smoother.
// No dependencies; every module of the block imports this package, and crps_channels uses its widths.
package crps_pkg;

    localparam int P_W    = 32;
    localparam int COEF_W = 36;
    localparam int SEG_W  = 6;

    localparam logic [SEG_W-1:0] SEG_RESET = 6'd8;

    // Horner passes: multiply by t, then add the next coefficient.
    localparam logic [1:0] HM_CUBIC  = 2'd0;
    localparam logic [1:0] HM_SQUARE = 2'd1;
    localparam logic [1:0] HM_LINEAR = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [P_W-1:0]    p1;
    } t_coef;

    typedef struct packed {
        t_coef x;
        t_coef y;
    } t_entry;

    typedef struct packed {
        logic       phase_a;
        logic       phase_b;
        logic [1:0] mult;
    } t_hctl;

endpackage

// ----- rtl/core/crps_channels.sv -----
// Stream channel interfaces of the path smoother: input points and smoothed points.
// Depends on crps_pkg for field widths.
interface crps_point_if;
    logic                             valid;
    logic                             ready;
    logic signed [crps_pkg::P_W-1:0]  point_x;
    logic signed [crps_pkg::P_W-1:0]  point_y;
    logic                             path_start;

    modport source (output valid, output point_x, output point_y, output path_start,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input path_start,
                    output ready);
endinterface

interface crps_smooth_if;
    logic                             valid;
    logic                             ready;
    logic signed [crps_pkg::P_W-1:0]  smooth_x;
    logic signed [crps_pkg::P_W-1:0]  smooth_y;
    logic                             run_last;

    modport source (output valid, output smooth_x, output smooth_y, output run_last,
                    input ready);
    modport sink   (input valid, input smooth_x, input smooth_y, input run_last,
                    output ready);
endinterface

// ----- rtl/core/catmull_rom_path_smoother_unit.sv -----
// Uniform Catmull-Rom path smoother, top level. Each accepted point of a path from the
// fourth onward yields N+1 saturated Q16.16 points from p1 to p2, N being the segment count
// (0 acts as 1), the last one flagged run_last. The Horner sequencer forms one partial
// product per cycle, holding while the output register has a point not yet taken, and a
// t-step division runs first whenever the segment count differs from the last one used.
// Two points can wait queued.
// Depends on crps_pkg, crps_channels, crps_front, crps_queue and crps_back.
module catmull_rom_path_smoother_unit #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [crps_pkg::SEG_W-1:0]  i_cfg_data,
    crps_point_if.sink                  i_point,
    crps_smooth_if.source               o_smooth
);
    import crps_pkg::*;

    logic [SEG_W-1:0] r_seg_cnt;
    logic [SEG_W-1:0] w_seg_eff;
    logic             w_push;
    logic             w_full;
    logic             w_q_valid;
    logic             w_pop;
    t_entry           w_push_entry;
    t_entry           w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_cnt <= SEG_RESET;
        end else if (i_cfg_wr_en) begin
            r_seg_cnt <= i_cfg_data;
        end
    end

    assign w_seg_eff = (r_seg_cnt == '0) ? SEG_W'(1) : r_seg_cnt;

    crps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_point.valid),
        .o_ready      (i_point.ready),
        .i_point_x    (i_point.point_x),
        .i_point_y    (i_point.point_y),
        .i_path_start (i_point.path_start),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    crps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_entry (w_head)
    );

    crps_back #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seg     (w_seg_eff),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_pop),
        .i_q_entry (w_head),
        .o_valid   (o_smooth.valid),
        .i_ready   (o_smooth.ready),
        .o_x       (o_smooth.smooth_x),
        .o_y       (o_smooth.smooth_y),
        .o_last    (o_smooth.run_last)
    );

endmodule

// ----- rtl/core/crps_front.sv -----
// Front end: accepts points, keeps the three-point window and forms spline coefficients.
// Depends on crps_pkg.
module crps_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [crps_pkg::P_W-1:0] i_point_x,
    input  logic signed [crps_pkg::P_W-1:0] i_point_y,
    input  logic                            i_path_start,
    input  logic                            i_q_full,
    output logic                            o_push,
    output crps_pkg::t_entry                o_entry
);
    import crps_pkg::*;

    function automatic t_coef f_coef(input logic signed [P_W-1:0] p0,
                                     input logic signed [P_W-1:0] p1,
                                     input logic signed [P_W-1:0] p2,
                                     input logic signed [P_W-1:0] p3);
        logic signed [COEF_W-1:0] e0;
        logic signed [COEF_W-1:0] e1;
        logic signed [COEF_W-1:0] e2;
        logic signed [COEF_W-1:0] e3;
        t_coef                    r;
        e0   = COEF_W'(p0);
        e1   = COEF_W'(p1);
        e2   = COEF_W'(p2);
        e3   = COEF_W'(p3);
        r.a  = e2 - e0;
        r.b  = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        r.c  = (e1 <<< 1) + e1 - ((e2 <<< 1) + e2) + e3 - e0;
        r.p1 = p1;
        return r;
    endfunction

    logic signed [P_W-1:0] r_wx [3];
    logic signed [P_W-1:0] r_wy [3];
    logic [1:0]            r_seen;
    logic [1:0]            w_seen;
    logic                  w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_seen   = i_path_start ? 2'd0 : r_seen;
    assign o_push   = w_accept && (w_seen == 2'd3);
    assign o_entry.x = f_coef(r_wx[0], r_wx[1], r_wx[2], i_point_x);
    assign o_entry.y = f_coef(r_wy[0], r_wy[1], r_wy[2], i_point_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
        end else if (w_accept) begin
            r_seen <= (w_seen == 2'd3) ? 2'd3 : w_seen + 2'd1;
        end
    end

    // The window is only read once three points of the path have been written.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wx[0] <= r_wx[1];
            r_wx[1] <= r_wx[2];
            r_wx[2] <= i_point_x;
            r_wy[0] <= r_wy[1];
            r_wy[1] <= r_wy[2];
            r_wy[2] <= i_point_y;
        end
    end

endmodule

// ----- rtl/core/crps_queue.sv -----
// Two-entry item queue between the front end and the interpolation back end.
// Depends on crps_pkg and the assertion macro header.
`include "catmull_rom_path_smoother_unit_macros.svh"

module crps_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crps_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output crps_pkg::t_entry o_entry
);
    import crps_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    `CRPS_ASSERT_NOW(a_no_overflow, i_push, r_cnt != 2'd2)
    `CRPS_ASSERT_NOW(a_no_underflow, i_pop, r_cnt != 2'd0)
    `CRPS_ASSERT_NOW(a_ptr_track, r_cnt == 2'd0 || r_cnt == 2'd2, r_wp == r_rp)

endmodule

// ----- rtl/core/crps_horner.sv -----
// One coordinate of the spline evaluator: Horner passes in t, one partial product a cycle while i_ctl advances.
// Depends on crps_pkg.
module crps_horner #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  crps_pkg::t_hctl                 i_ctl,
    input  crps_pkg::t_coef                 i_coef,
    input  logic [PARAM_FRAC_BITS:0]        i_t,
    output logic signed [crps_pkg::P_W-1:0] o_result
);
    import crps_pkg::*;

    localparam int PF = PARAM_FRAC_BITS;
    localparam int TW = PF + 1;
    localparam int NW = 38 + 2 * PF;
    localparam int LW = (NW + 1) / 2;
    localparam int HW = NW - LW;
    localparam int AW = 39 + 3 * PF;
    localparam int SH = 3 * PF + 1;
    localparam int QW = AW - SH;

    logic signed [NW-1:0]    r_n;
    logic signed [AW-1:0]    r_acc;
    logic signed [NW-1:0]    w_mcand;
    logic [LW-1:0]           w_lo;
    logic signed [HW-1:0]    w_hi;
    logic signed [TW:0]      w_ts;
    logic signed [LW+TW:0]   w_plo;
    logic signed [HW+TW:0]   w_phi;
    logic signed [AW-1:0]    w_k;
    logic signed [AW-1:0]    w_sum;
    logic signed [QW-1:0]    w_q;

    // The first pass multiplies the cubic coefficient itself.
    assign w_mcand = (i_ctl.mult == HM_CUBIC) ? NW'(i_coef.c) : r_n;
    assign w_lo    = w_mcand[LW-1:0];
    assign w_hi    = w_mcand[NW-1:LW];
    assign w_ts    = $signed({1'b0, i_t});
    assign w_plo   = $signed({1'b0, w_lo}) * w_ts;
    assign w_phi   = w_hi * w_ts;

    always_comb begin
        case (i_ctl.mult)
            HM_CUBIC:  w_k = AW'(i_coef.b) <<< PF;
            HM_SQUARE: w_k = AW'(i_coef.a) <<< (2 * PF);
            HM_LINEAR: w_k = AW'(i_coef.p1) <<< SH;
            default:   w_k = '0;
        endcase
    end

    assign w_sum = r_acc + (AW'(w_phi) <<< LW);
    assign w_q   = w_sum[AW-1:SH];

    always_comb begin
        if (w_q[QW-1:P_W-1] == {(QW-P_W+1){w_q[P_W-1]}}) begin
            o_result = w_q[P_W-1:0];
        end else if (w_q[QW-1]) begin
            o_result = {1'b1, {(P_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(P_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.phase_a) begin
            r_acc <= w_k + AW'(w_plo);
        end
        if (i_ctl.phase_b && (i_ctl.mult != HM_LINEAR)) begin
            r_n <= w_sum[NW-1:0];
        end
    end

endmodule

// ----- rtl/core/crps_back.sv -----
// Back end: steps the spline parameter, sequences both evaluators, holds the result register.
// Depends on crps_pkg, crps_horner and the assertion macro header.
`include "catmull_rom_path_smoother_unit_macros.svh"

module crps_back #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [crps_pkg::SEG_W-1:0]        i_seg,
    input  logic                              i_q_valid,
    output logic                              o_q_pop,
    input  crps_pkg::t_entry                  i_q_entry,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [crps_pkg::P_W-1:0]   o_x,
    output logic signed [crps_pkg::P_W-1:0]   o_y,
    output logic                              o_last
);
    import crps_pkg::*;

    localparam int PF   = PARAM_FRAC_BITS;
    localparam int TW   = PF + 1;
    localparam int CNTW = $clog2(PF + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;

    localparam logic [2:0] STEP_LAST = 3'd5;
    localparam logic [TW-1:0] T_ONE = {1'b1, {PF{1'b0}}};

    logic [1:0]          r_state, n_state;
    logic [2:0]          r_step, n_step;
    logic [SEG_W-1:0]    r_j, n_j;
    logic [SEG_W-1:0]    r_seg_run, n_seg_run;
    logic [TW-1:0]       r_t, n_t;
    logic [SEG_W-1:0]    r_rem, n_rem;
    logic [TW-1:0]       r_q, n_q;
    logic [SEG_W-1:0]    r_qr, n_qr;
    logic                r_div_ok, n_div_ok;
    logic [SEG_W-1:0]    r_div_seg, n_div_seg;
    logic [CNTW-1:0]     r_div_cnt, n_div_cnt;
    logic [SEG_W-1:0]    r_div_rem, n_div_rem;
    t_coef               r_cx, n_cx;
    t_coef               r_cy, n_cy;
    logic                r_ovalid, n_ovalid;
    logic signed [P_W-1:0] r_ox, n_ox;
    logic signed [P_W-1:0] r_oy, n_oy;
    logic                r_olast, n_olast;

    logic [SEG_W:0]      w_dsh;
    logic                w_dge;
    logic [SEG_W:0]      w_dnew;
    logic [SEG_W:0]      w_rsum;
    logic                w_wrap;
    logic [SEG_W:0]      w_rnew;
    logic                w_out_free;
    t_hctl               w_ctl;
    logic signed [P_W-1:0] w_rx;
    logic signed [P_W-1:0] w_ry;

    // Restoring division of 2^PF by the segment count, one quotient bit a cycle.
    assign w_dsh  = {r_div_rem, (r_div_cnt == '0)};
    assign w_dge  = (w_dsh >= {1'b0, r_seg_run});
    assign w_dnew = w_dge ? w_dsh - {1'b0, r_seg_run} : w_dsh;

    // t advances by the quotient, with the remainder carried as in long division.
    assign w_rsum = {1'b0, r_rem} + {1'b0, r_qr};
    assign w_wrap = (w_rsum >= {1'b0, r_seg_run});
    assign w_rnew = w_wrap ? w_rsum - {1'b0, r_seg_run} : w_rsum;

    assign w_out_free    = !r_ovalid || i_ready;
    assign w_ctl.phase_a = (r_state == ST_CALC) && !r_step[0];
    assign w_ctl.phase_b = (r_state == ST_CALC) && r_step[0];
    assign w_ctl.mult    = r_step[2:1];

    crps_horner #(.PARAM_FRAC_BITS(PF)) u_horner_x (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_coef   (r_cx),
        .i_t      (r_t),
        .o_result (w_rx)
    );

    crps_horner #(.PARAM_FRAC_BITS(PF)) u_horner_y (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_coef   (r_cy),
        .i_t      (r_t),
        .o_result (w_ry)
    );

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid = r_ovalid;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_last  = r_olast;

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_j       = r_j;
        n_seg_run = r_seg_run;
        n_t       = r_t;
        n_rem     = r_rem;
        n_q       = r_q;
        n_qr      = r_qr;
        n_div_ok  = r_div_ok;
        n_div_seg = r_div_seg;
        n_div_cnt = r_div_cnt;
        n_div_rem = r_div_rem;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_ovalid  = r_ovalid && !i_ready;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_olast   = r_olast;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cx      = i_q_entry.x;
                    n_cy      = i_q_entry.y;
                    n_seg_run = i_seg;
                    n_j       = '0;
                    n_t       = '0;
                    n_rem     = '0;
                    n_step    = '0;
                    n_div_cnt = '0;
                    n_div_rem = '0;
                    if (r_div_ok && (r_div_seg == i_seg)) begin
                        n_state = ST_CALC;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_div_rem = w_dnew[SEG_W-1:0];
                n_q       = {r_q[TW-2:0], w_dge};
                n_div_cnt = r_div_cnt + CNTW'(1);
                if (r_div_cnt == CNTW'(PF)) begin
                    n_div_ok  = 1'b1;
                    n_div_seg = r_seg_run;
                    n_qr      = w_dnew[SEG_W-1:0];
                    n_state   = ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_step != STEP_LAST) begin
                    n_step = r_step + 3'd1;
                end else if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ox     = w_rx;
                    n_oy     = w_ry;
                    n_olast  = (r_j == r_seg_run);
                    n_step   = '0;
                    if (r_j == r_seg_run) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j   = r_j + 1'b1;
                        n_t   = r_t + r_q + TW'(w_wrap);
                        n_rem = w_rnew[SEG_W-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_div_ok  <= 1'b0;
            r_div_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_div_ok  <= n_div_ok;
            r_div_cnt <= n_div_cnt;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_seg_run <= n_seg_run;
        r_t       <= n_t;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_qr      <= n_qr;
        r_div_seg <= n_div_seg;
        r_div_rem <= n_div_rem;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_olast   <= n_olast;
    end

    `CRPS_ASSERT_NOW(a_j_range, r_state == ST_CALC, r_j <= r_seg_run)
    `CRPS_ASSERT_NOW(a_rem_range, r_state == ST_CALC, r_rem < r_seg_run)
    `CRPS_ASSERT_NOW(a_t_ends_at_one, (r_state == ST_CALC) && (r_j == r_seg_run), r_t == T_ONE)

endmodule

// ----- verif/catmull_rom_path_smoother_unit_tb.sv -----
// Self-checking testbench of catmull_rom_path_smoother_unit: directed and random paths,
// with each smoothed point checked against an exact 128-bit Catmull-Rom predictor.
// Depends on crps_pkg, crps_channels and the RTL of the smoother.
`timescale 1ns / 100ps

module catmull_rom_path_smoother_unit_tb;
    import crps_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          DRAIN_CYCLES = 500;
    localparam logic [31:0] MAX_POS      = 32'h7fffffff;
    localparam logic [31:0] MAX_NEG      = 32'h80000000;

    typedef struct {
        logic signed [P_W-1:0] x;
        logic signed [P_W-1:0] y;
        logic                  last;
    } t_smooth_pt;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        start;
        logic        known;
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
    } t_point_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [SEG_W-1:0]     i_cfg_data;
    crps_point_if         pt_if ();
    crps_smooth_if        sm_if ();

    t_smooth_pt           expected_pts[$];
    logic [SEG_W-1:0]     seg_count;
    logic signed [P_W-1:0] win_x[3];
    logic signed [P_W-1:0] win_y[3];
    int                   held_points;
    int                   fail_count;
    int                   quiet_cycles;
    logic                 no_idle;

    catmull_rom_path_smoother_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_data  (i_cfg_data),
        .i_point     (pt_if),
        .o_smooth    (sm_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Exact evaluation of one coordinate at parameter t = tval / 2^16, then saturation.
    function automatic logic signed [P_W-1:0] blend(input logic signed [P_W-1:0] p0,
            input logic signed [P_W-1:0] p1, input logic signed [P_W-1:0] p2,
            input logic signed [P_W-1:0] p3, input logic [16:0] tval);
        logic signed [127:0] w0, w1, w2, w3, ca, cb, cc, tt, acc;
        begin
            w0 = p0; w1 = p1; w2 = p2; w3 = p3;
            tt = {111'd0, tval};
            ca = w2 - w0;
            cb = 2 * w0 - 5 * w1 + 4 * w2 - w3;
            cc = -w0 + 3 * w1 - 3 * w2 + w3;
            acc = cc * tt + (cb <<< 16);
            acc = acc * tt + (ca <<< 32);
            acc = acc * tt + ((2 * w1) <<< 48);
            acc = acc >>> 49;
            if (acc > $signed({96'd0, MAX_POS}))
                return MAX_POS;
            if (acc < -$signed(128'sh80000000))
                return MAX_NEG;
            return acc[31:0];
        end
    endfunction

    // Updates the point window and returns the smoothed run the point causes.
    task automatic predict_run(input t_point_row row, output t_smooth_pt run[$]);
        int seg;
        logic [16:0] tval;
        t_smooth_pt sp;
        begin
            run = {};
            if (row.start)
                held_points = 0;
            if (held_points >= 3) begin
                seg = (seg_count == 0) ? 1 : seg_count;
                for (int j = 0; j <= seg; j++) begin
                    tval = 17'((j * 65536) / seg);
                    sp.x = blend(win_x[0], win_x[1], win_x[2], row.x, tval);
                    sp.y = blend(win_y[0], win_y[1], win_y[2], row.y, tval);
                    sp.last = (j == seg);
                    run = {run, sp};
                end
            end
            win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = row.x;
            win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = row.y;
            if (held_points < 3)
                held_points++;
        end
    endtask

    task automatic send_point(input t_point_row row);
        t_smooth_pt run[$];
        begin
            @(negedge i_clk);
            while (!no_idle && $urandom_range(99) < 33) begin
                pt_if.valid = 1'b0;
                @(negedge i_clk);
            end
            pt_if.valid      = 1'b1;
            pt_if.point_x    = row.x;
            pt_if.point_y    = row.y;
            pt_if.path_start = row.start;
            @(posedge i_clk);
            while (!pt_if.ready)
                @(posedge i_clk);
            predict_run(row, run);
            // Rows with hand-written values pin the run ends: t=0 gives p1, t=1 gives p2.
            if (row.known && run.size() > 0) begin
                run[0].x = row.first_x;
                run[0].y = row.first_y;
                run[run.size()-1].x = row.end_x;
                run[run.size()-1].y = row.end_y;
            end
            foreach (run[k])
                expected_pts = {expected_pts, run[k]};
        end
    endtask

    task automatic write_seg_count(input logic [SEG_W-1:0] value);
        begin
            @(negedge i_clk);
            pt_if.valid = 1'b0;
            while (expected_pts.size() > 0)
                @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            @(negedge i_clk);
            i_cfg_wr_en = 1'b1;
            i_cfg_data  = value;
            seg_count   = value;
            @(negedge i_clk);
            i_cfg_wr_en = 1'b0;
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 0) ? MAX_POS - $urandom_range(255)
                                           : MAX_NEG + $urandom_range(255);
            default: return $urandom_range(32'h00ffffff) - 32'h00800000;
        endcase
    endfunction

    task automatic random_paths(input int n_items);
        t_point_row row;
        int sent, len;
        begin
            sent = 0;
            row.known = 1'b0;
            while (sent < n_items) begin
                len = $urandom_range(12, 1);
                for (int i = 0; i < len && sent < n_items; i++) begin
                    row.x = rand_coord();
                    row.y = rand_coord();
                    // Mostly well-formed paths; now and then a stray restart.
                    row.start = (i == 0) || ($urandom_range(99) < 4);
                    send_point(row);
                    sent++;
                end
            end
        end
    endtask

    always @(negedge i_clk)
        sm_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);

    always @(posedge i_clk) begin
        t_smooth_pt want;
        if (i_rst_n && sm_if.valid && sm_if.ready) begin
            if (expected_pts.size() == 0) begin
                $display("%0t: unexpected point x=%h y=%h last=%b", $time,
                         sm_if.smooth_x, sm_if.smooth_y, sm_if.run_last);
                fail_count++;
            end else begin
                want = expected_pts.pop_front();
                if (want.x !== sm_if.smooth_x || want.y !== sm_if.smooth_y
                        || want.last !== sm_if.run_last) begin
                    $display("%0t: expected x=%h y=%h last=%b, actual x=%h y=%h last=%b",
                             $time, want.x, want.y, want.last,
                             sm_if.smooth_x, sm_if.smooth_y, sm_if.run_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (sm_if.valid && sm_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("catmull_rom_path_smoother_unit: mismatch");
            $finish;
        end
    end

    initial begin
        t_point_row rows[16];
        logic [SEG_W-1:0] phase_counts[8];
        rows = '{
            '{32'h0, 32'h0, 1, 0, 0, 0, 0, 0},
            '{32'h0, 32'h0, 0, 0, 0, 0, 0, 0},
            '{32'h0, 32'h0, 0, 0, 0, 0, 0, 0},
            '{32'h0, 32'h0, 0, 1, 32'h0, 32'h0, 32'h0, 32'h0},
            '{MAX_POS, MAX_NEG, 1, 0, 0, 0, 0, 0},
            '{MAX_NEG, MAX_POS, 0, 0, 0, 0, 0, 0},
            '{MAX_POS, MAX_NEG, 0, 0, 0, 0, 0, 0},
            '{MAX_NEG, MAX_POS, 0, 1, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG},
            '{32'h00010000, 32'hffff0000, 0, 1, MAX_POS, MAX_NEG, MAX_NEG, MAX_POS},
            '{32'h1, 32'hffffffff, 1, 0, 0, 0, 0, 0},
            '{32'h2, 32'hfffffffe, 0, 0, 0, 0, 0, 0},
            '{32'h5, 32'h7, 1, 0, 0, 0, 0, 0},
            '{32'h12345678, 32'h87654321, 0, 0, 0, 0, 0, 0},
            '{32'hedcba987, 32'h0f0f0f0f, 0, 0, 0, 0, 0, 0},
            '{32'h55555555, 32'haaaaaaaa, 0, 1, 32'h12345678, 32'h87654321,
              32'hedcba987, 32'h0f0f0f0f},
            '{32'haaaaaaaa, 32'h55555555, 0, 1, 32'hedcba987, 32'h0f0f0f0f,
              32'h55555555, 32'haaaaaaaa}
        };
        phase_counts = '{6'd0, 6'd63, 6'd1, 6'd8, 6'd0, 6'd0, 6'd0, 6'd1};
        fail_count       = 0;
        no_idle          = 1'b0;
        seg_count        = SEG_RESET;
        held_points      = 0;
        for (int i = 0; i < 3; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_data       = '0;
        pt_if.valid      = 1'b0;
        pt_if.point_x    = '0;
        pt_if.point_y    = '0;
        pt_if.path_start = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[r])
            send_point(rows[r]);

        for (int p = 0; p < 8; p++) begin
            if (p >= 4)
                phase_counts[p] = SEG_W'($urandom_range(63, 0));
            write_seg_count(phase_counts[p]);
            no_idle = (p == 2);
            random_paths(phase_counts[p] > 40 ? 30 : 60);
        end
        no_idle = 1'b0;

        @(negedge i_clk);
        pt_if.valid = 1'b0;
        while (expected_pts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("catmull_rom_path_smoother_unit: match");
        else
            $display("catmull_rom_path_smoother_unit: mismatch");
        $finish;
    end

endmodule
